// ===== src/rbyc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbyc_pkg
// Shared types and coefficients for the 2x2 RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
package rbyc_pkg;

  localparam int NUM_PIX = 4;

  typedef logic [23:0] pixel_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
  } lane_res_t;

  localparam logic [15:0] Y_R  = 16'd66;
  localparam logic [15:0] Y_G  = 16'd129;
  localparam logic [15:0] Y_B  = 16'd25;
  localparam logic [15:0] RND  = 16'd128;

  localparam logic [15:0] CB_R = 16'd38;
  localparam logic [15:0] CB_G = 16'd74;
  localparam logic [15:0] CB_B = 16'd112;

  localparam logic [15:0] CR_R = 16'd112;
  localparam logic [15:0] CR_G = 16'd94;
  localparam logic [15:0] CR_B = 16'd18;

  // 112*256 offset keeps the chroma numerator positive, plus rounding
  localparam logic [15:0] CHROMA_BIAS = 16'd28800;
  localparam logic [7:0]  OUT_OFFSET  = 8'd16;

endpackage

// ===== src/rbyc_lane.sv =====
// ----------------------------------------------------------------------------
// rbyc_lane
// Per-pixel core: luma and unaveraged Cb/Cr of one pixel, registered.
// ----------------------------------------------------------------------------
module rbyc_lane (
  input  logic              clk,
  input  logic              en,
  input  rbyc_pkg::pixel_t  pixel,
  output rbyc_pkg::lane_res_t res_r
);
  import rbyc_pkg::*;

  logic [15:0] r, g, b;
  logic [15:0] y_acc, cb_acc, cr_acc;
  lane_res_t   res_nxt;

  assign r = {8'd0, pixel[23:16]};
  assign g = {8'd0, pixel[15:8]};
  assign b = {8'd0, pixel[7:0]};

  // all sums land in 0..57360, so 16-bit wraparound cancels out
  assign y_acc  = r * Y_R + g * Y_G + b * Y_B + RND;
  assign cb_acc = b * CB_B + CHROMA_BIAS - r * CB_R - g * CB_G;
  assign cr_acc = r * CR_R + CHROMA_BIAS - g * CR_G - b * CR_B;

  always_comb begin
    res_nxt.y  = y_acc[15:8] + OUT_OFFSET;
    res_nxt.cb = cb_acc[15:8] + OUT_OFFSET;
    res_nxt.cr = cr_acc[15:8] + OUT_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/rbyc_merge.sv =====
// ----------------------------------------------------------------------------
// rbyc_merge
// Combines the four lanes: passes luma, averages chroma with rounding.
// ----------------------------------------------------------------------------
module rbyc_merge (
  input  logic                clk,
  input  logic                en,
  input  rbyc_pkg::lane_res_t lane [rbyc_pkg::NUM_PIX],
  output logic [7:0]          luma_r [rbyc_pkg::NUM_PIX],
  output logic [7:0]          cb_r,
  output logic [7:0]          cr_r
);
  import rbyc_pkg::*;

  logic [9:0] cb_sum, cr_sum;

  // four values of at most 240 plus 2 stay below 1024; sum/4 fits 8 bits
  always_comb begin
    cb_sum = 10'd2;
    cr_sum = 10'd2;
    for (int i = 0; i < NUM_PIX; i++) begin
      cb_sum = cb_sum + {2'd0, lane[i].cb};
      cr_sum = cr_sum + {2'd0, lane[i].cr};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_PIX; i++) begin
        luma_r[i] <= lane[i].y;
      end
      cb_r <= cb_sum[9:2];
      cr_r <= cr_sum[9:2];
    end
  end

endmodule

// ===== src/rgb_block_to_ycbcr420.sv =====
// ----------------------------------------------------------------------------
// rgb_block_to_ycbcr420
// 2x2 RGB block to four BT.601 luma bytes and one averaged Cb/Cr pair.
// Throughput: one block per cycle while out_stall is low.
// Four lanes plus a merge stage, each registered.
// Reset: synchronous rst_n clears both stage valid flags; data regs are not reset.
// ----------------------------------------------------------------------------
module rgb_block_to_ycbcr420 (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [23:0]          in_pixel_top_left,
  input  logic [23:0]          in_pixel_top_right,
  input  logic [23:0]          in_pixel_bottom_left,
  input  logic [23:0]          in_pixel_bottom_right,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_luma_top_left,
  output logic [7:0]           out_luma_top_right,
  output logic [7:0]           out_luma_bottom_left,
  output logic [7:0]           out_luma_bottom_right,
  output logic [7:0]           out_blue_chroma,
  output logic [7:0]           out_red_chroma
);
  import rbyc_pkg::*;

  pixel_t    pix [NUM_PIX];
  lane_res_t lane_res [NUM_PIX];
  logic [7:0] luma [NUM_PIX];

  logic lane_v_r, lane_v_nxt;
  logic out_v_r, out_v_nxt;
  logic adv_out, adv_lane;

  assign pix[0] = in_pixel_top_left;
  assign pix[1] = in_pixel_top_right;
  assign pix[2] = in_pixel_bottom_left;
  assign pix[3] = in_pixel_bottom_right;

  assign adv_out  = !out_v_r || !out_stall;
  assign adv_lane = !lane_v_r || adv_out;
  assign in_stall = !adv_lane;

  assign lane_v_nxt = adv_lane ? in_valid : lane_v_r;
  assign out_v_nxt  = adv_out ? lane_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      lane_v_r <= lane_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  for (genvar i = 0; i < NUM_PIX; i++) begin : g_lane
    rbyc_lane u_lane (
      .clk   (clk),
      .en    (adv_lane && in_valid),
      .pixel (pix[i]),
      .res_r (lane_res[i])
    );
  end

  rbyc_merge u_merge (
    .clk    (clk),
    .en     (adv_out && lane_v_r),
    .lane   (lane_res),
    .luma_r (luma),
    .cb_r   (out_blue_chroma),
    .cr_r   (out_red_chroma)
  );

  assign out_valid             = out_v_r;
  assign out_luma_top_left     = luma[0];
  assign out_luma_top_right    = luma[1];
  assign out_luma_bottom_left  = luma[2];
  assign out_luma_bottom_right = luma[3];

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (lane_v_r && out_valid && out_stall))
    else $error("input stalled while pipeline has room");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> lane_v_r)
    else $error("accepted block lost from lane stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !lane_v_r) |=> !out_valid)
    else $error("result repeated after transfer");

  a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_luma_top_left >= 8'd16 && out_luma_top_left <= 8'd235 &&
                   out_blue_chroma >= 8'd16 && out_blue_chroma <= 8'd240))
    else $error("output outside studio range");

endmodule

// ===== dv/rgb_block_to_ycbcr420_test.sv =====
// ----------------------------------------------------------------------------
// rgb_block_to_ycbcr420_test
// Self-checking bench for the 2x2 RGB to YCbCr 4:2:0 block converter. A
// directed table covers primaries, extremes and mixed blocks. About 1250
// random blocks follow. Every output transfer is checked field by field
// against the typed table values or an in-bench BT.601 predictor. Both sides
// insert random gaps, and one long output hold backs up the pipeline.
// ----------------------------------------------------------------------------
module rgb_block_to_ycbcr420_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbyc_pkg::*;

  typedef struct packed {
    pixel_t tl;
    pixel_t tr;
    pixel_t bl;
    pixel_t br;
  } rgb_block_t;

  typedef struct packed {
    logic [7:0] luma_tl;
    logic [7:0] luma_tr;
    logic [7:0] luma_bl;
    logic [7:0] luma_br;
    logic [7:0] cb;
    logic [7:0] cr;
  } ycc_block_t;

  typedef struct packed {
    rgb_block_t blk;
    logic       typed;
    ycc_block_t want;
  } directed_row_t;

  localparam int NUM_DIRECTED = 14;
  localparam int NUM_RANDOM   = 1250;
  localparam int MAX_WAIT     = 8;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 200000;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{24'h000000, 24'h000000, 24'h000000, 24'h000000}, 1'b1,
      '{8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128}},
    '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
      '{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128}},
    '{'{24'hFF0000, 24'hFF0000, 24'hFF0000, 24'hFF0000}, 1'b1,
      '{8'd82, 8'd82, 8'd82, 8'd82, 8'd90, 8'd240}},
    '{'{24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00}, 1'b1,
      '{8'd144, 8'd144, 8'd144, 8'd144, 8'd54, 8'd34}},
    '{'{24'h0000FF, 24'h0000FF, 24'h0000FF, 24'h0000FF}, 1'b1,
      '{8'd41, 8'd41, 8'd41, 8'd41, 8'd240, 8'd110}},
    '{'{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF}, 1'b0, '0},
    '{'{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000}, 1'b0, '0},
    '{'{24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080}, 1'b0, '0},
    '{'{24'h010101, 24'h7F7F7F, 24'h808080, 24'hFEFEFE}, 1'b0, '0},
    '{'{24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA}, 1'b0, '0},
    '{'{24'h800000, 24'h008000, 24'h000080, 24'h000001}, 1'b0, '0},
    '{'{24'h0000FF, 24'h0000FF, 24'hFF0000, 24'hFF0000}, 1'b0, '0},
    '{'{24'h00FF00, 24'h00FF00, 24'h00FF00, 24'hFF00FF}, 1'b0, '0},
    '{'{24'h123456, 24'hABCDEF, 24'hFEDCBA, 24'h0F0F0F}, 1'b0, '0}
  };

  localparam string FIELD_NAMES [6] = '{
    "luma_top_left", "luma_top_right", "luma_bottom_left",
    "luma_bottom_right", "blue_chroma", "red_chroma"
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [23:0] in_pixel_top_left = '0;
  logic [23:0] in_pixel_top_right = '0;
  logic [23:0] in_pixel_bottom_left = '0;
  logic [23:0] in_pixel_bottom_right = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_luma_top_left;
  logic [7:0] out_luma_top_right;
  logic [7:0] out_luma_bottom_left;
  logic [7:0] out_luma_bottom_right;
  logic [7:0] out_blue_chroma;
  logic [7:0] out_red_chroma;

  ycc_block_t pending_ycc [$];
  bit          quiet = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned blocks_sent = 0;
  int unsigned blocks_checked = 0;
  int unsigned mismatches = 0;
  int unsigned out_wait = 0;
  int unsigned cycles = 0;

  rgb_block_to_ycbcr420 dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_pixel_top_left     (in_pixel_top_left),
    .in_pixel_top_right    (in_pixel_top_right),
    .in_pixel_bottom_left  (in_pixel_bottom_left),
    .in_pixel_bottom_right (in_pixel_bottom_right),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_luma_top_left     (out_luma_top_left),
    .out_luma_top_right    (out_luma_top_right),
    .out_luma_bottom_left  (out_luma_bottom_left),
    .out_luma_bottom_right (out_luma_bottom_right),
    .out_blue_chroma       (out_blue_chroma),
    .out_red_chroma        (out_red_chroma)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] sat8(input int v);
    if (v > 255) return 8'd255;
    if (v < 0) return 8'd0;
    return v[7:0];
  endfunction

  // BT.601 studio swing; chroma rounded per pixel, then rounded 4-pixel mean
  function automatic ycc_block_t convert_block(input rgb_block_t blk);
    pixel_t     px [NUM_PIX];
    logic [7:0] luma [NUM_PIX];
    int         red, grn, blu, cb_sum, cr_sum;
    ycc_block_t res;
    px = '{blk.tl, blk.tr, blk.bl, blk.br};
    cb_sum = 0;
    cr_sum = 0;
    for (int i = 0; i < NUM_PIX; i++) begin
      red = int'(px[i][23:16]);
      grn = int'(px[i][15:8]);
      blu = int'(px[i][7:0]);
      luma[i] = sat8(((66 * red + 129 * grn + 25 * blu + 128) >>> 8) + 16);
      cb_sum += ((112 * blu - 38 * red - 74 * grn + 128) >>> 8) + 128;
      cr_sum += ((112 * red - 94 * grn - 18 * blu + 128) >>> 8) + 128;
    end
    res.luma_tl = luma[0];
    res.luma_tr = luma[1];
    res.luma_bl = luma[2];
    res.luma_br = luma[3];
    res.cb = sat8((cb_sum + 2) >>> 2);
    res.cr = sat8((cr_sum + 2) >>> 2);
    return res;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic rgb_block_t rand_block();
    rgb_block_t blk;
    pixel_t     px;
    case ($urandom_range(0, 9))
      0, 1: begin
        px = 24'($urandom);
        blk = '{px, px, px, px};
      end
      2, 3: begin
        blk.tl = {rand_channel(), rand_channel(), rand_channel()};
        blk.tr = {rand_channel(), rand_channel(), rand_channel()};
        blk.bl = {rand_channel(), rand_channel(), rand_channel()};
        blk.br = {rand_channel(), rand_channel(), rand_channel()};
      end
      default: begin
        blk = '{24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
      end
    endcase
    return blk;
  endfunction

  task automatic send_block(input rgb_block_t blk, input logic typed,
                            input ycc_block_t want);
    int unsigned gap;
    gap = (quiet || long_hold) ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_top_left <= blk.tl;
    in_pixel_top_right <= blk.tr;
    in_pixel_bottom_left <= blk.bl;
    in_pixel_bottom_right <= blk.br;
    do @(posedge clk); while (in_stall);
    pending_ycc.push_back(typed ? want : convert_block(blk));
    blocks_sent++;
  endtask

  // output side: check each transfer, then draw the stall before the next one
  always @(posedge clk) begin
    ycc_block_t got;
    ycc_block_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_luma_top_left, out_luma_top_right, out_luma_bottom_left,
               out_luma_bottom_right, out_blue_chroma, out_red_chroma};
        if (pending_ycc.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected output transfer: %h", got);
          mismatches++;
        end else begin
          want = pending_ycc.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got[47 - 8 * k -: 8] !== want[47 - 8 * k -: 8]) begin
              if (mismatches < 10)
                $display("block %0d %s: expected %0d, got %0d", blocks_checked,
                         FIELD_NAMES[k], want[47 - 8 * k -: 8], got[47 - 8 * k -: 8]);
              mismatches++;
            end
          end
          blocks_checked++;
        end
        out_wait = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else if (out_wait != 0) begin
        out_stall <= 1'b1;
        out_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long output hold while the input keeps offering blocks
  initial begin
    wait (blocks_sent >= 300);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_ycc.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_block(DIRECTED_ROWS[i].blk, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet <= (n % 250) >= 200;
      send_block(rand_block(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait (pending_ycc.size() == 0);
    repeat (8) @(posedge clk);
    $display("%0d blocks checked: %0d directed (primaries, extremes, mixed), %0d random",
             blocks_checked, NUM_DIRECTED, NUM_RANDOM);
    $display("random gaps on both sides, idle-free stretches, one %0d-cycle output hold",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
